@@ sv/battery_rc_model_step_defines.svh @@
// ----------------------------------------------------------------------------
// Battery RC model step - assertion macros
// Shared property wrappers, clocked on clock and masked during reset.
// ----------------------------------------------------------------------------
`ifndef BATTERY_RC_MODEL_STEP_DEFINES_SVH
`define BATTERY_RC_MODEL_STEP_DEFINES_SVH

// same-cycle implication
`define BRMS_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BRMS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/brms_pkg.sv @@
// ----------------------------------------------------------------------------
// Battery RC model step - package
// Types, register and table codes, and saturation shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package brms_pkg;

   localparam int KEY_W      = 21;
   localparam int REQ_DATA_W = 176;
   localparam int RSP_DATA_W = 112;
   localparam int KEY_SCALE  = 20;
   localparam int SECONDS_PER_HOUR = 3600;

   localparam logic [2:0] REG_TIME_STEP  = 3'd0;
   localparam logic [2:0] REG_SOC_START  = 3'd1;
   localparam logic [2:0] REG_SOC_POINTS = 3'd2;
   localparam logic [2:0] REG_CUR_POINTS = 3'd3;
   localparam logic [2:0] REG_BRANCHES   = 3'd4;

   localparam logic [2:0] TBL_SOC_BP   = 3'd0;
   localparam logic [2:0] TBL_CUR_BP   = 3'd1;
   localparam logic [2:0] TBL_CAPACITY = 3'd2;
   localparam logic [2:0] TBL_OCV      = 3'd3;
   localparam logic [2:0] TBL_R0       = 3'd4;
   localparam logic [2:0] TBL_BR_R     = 3'd5;
   localparam logic [2:0] TBL_BR_C     = 3'd6;

   localparam logic [31:0] TIME_STEP_RST = 32'h0001_0000;
   localparam logic [4:0]  POINTS_RST    = 5'd16;
   localparam logic [2:0]  BRANCHES_RST  = 3'd2;

   localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
   localparam logic signed [63:0] S64_HI  = 64'sh0000_0000_7fff_ffff;
   localparam logic signed [63:0] S64_LO  = -64'sh0000_0000_8000_0000;

   typedef enum logic [4:0] {
      ST_IDLE, ST_WRITE, ST_PREP, ST_SRCH_RD, ST_SRCH_CMP, ST_CAP_MUL, ST_NUM_MUL,
      ST_SOC_DIV_GO, ST_SOC_DIV_WAIT, ST_SOC_KEY, ST_BR_START, ST_BR_RD, ST_BR_TAU,
      ST_BR_DIV1_GO, ST_BR_DIV1_WAIT, ST_BR_DIV2_GO, ST_BR_DIV2_WAIT, ST_BR_MUL,
      ST_BR_UPD, ST_OUT_MUL, ST_OUT_SUM, ST_FINISH
   } seq_state_type;

   typedef enum logic [1:0] {PH_FAST, PH_SLOW, PH_SOC} search_phase_type;

   typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_DONE} div_state_type;

   typedef struct packed {
      logic done;
      logic zero;
   } div_status_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > S64_HI) r = S32_MAX;
      else if (v < S64_LO) r = S32_MIN;
      else r = v[31:0];
      return r;
   endfunction

endpackage

`default_nettype wire

@@ sv/battery_rc_model_step.sv @@
// ----------------------------------------------------------------------------
// Battery RC model step - top level
// Lookup-table equivalent-circuit cell model advanced once per current sample.
// ----------------------------------------------------------------------------
// A table-write item is written in the write state and acknowledged from
// the finish state. A model step runs the fast-current and slow-current
// breakpoint searches, the SOC update, the SOC search, the work for each of
// the nb RC branches in use and the output sum; each search visits its
// breakpoints with one read of the breakpoint memory and one compare. The
// shared divider yields one quotient bit a cycle and ends early when the
// divisor is zero or the quotient overflows; it serves one division for the
// SOC update and two for each branch. The tables sit in memories with
// registered reads and hold no reset value, so no clearing pass runs after
// reset; every entry must be written before use. A new item is taken while
// the previous result still waits at the output.
`default_nettype none
`include "battery_rc_model_step_defines.svh"

module battery_rc_model_step #(
   parameter int SOC_POINTS     = 16,
   parameter int CURRENT_POINTS = 16,
   parameter int RC_BRANCHES    = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   // first_of_run, current, current_fast, current_slow, measured_voltage,
   // table_select, branch_number, row_number, column_number, table_value
   input  logic [brms_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [0:0]                        req_tuser,   // command
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // terminal_voltage, state_of_charge, residual, soc_row, fast_column,
   // slow_column, divide_error
   output logic [brms_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [0:0]                        rsp_tuser,   // is_estimate
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [4:0]                        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam int MAXP   = (SOC_POINTS > CURRENT_POINTS) ? SOC_POINTS : CURRENT_POINTS;
   localparam int SW     = $clog2(SOC_POINTS);
   localparam int CW     = $clog2(CURRENT_POINTS);
   localparam int IW     = $clog2(MAXP);
   localparam int NW     = $clog2(MAXP + 1);
   localparam int BW     = (RC_BRANCHES > 1) ? $clog2(RC_BRANCHES) : 1;
   localparam int KW     = $clog2(RC_BRANCHES + 1);
   localparam int CELLS  = SOC_POINTS * CURRENT_POINTS;
   localparam int OAW    = $clog2(CELLS);
   localparam int BCELLS = RC_BRANCHES * CELLS;
   localparam int BAW    = $clog2(BCELLS);
   localparam int KEY_W  = brms_pkg::KEY_W;

   // ---------------------------------------------------------------- config
   logic [31:0]        time_step_ff;
   logic signed [31:0] soc_start_ff;
   logic [4:0]         soc_pts_ff, cur_pts_ff;
   logic [2:0]         branches_ff;
   logic               csr_wr;

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= brms_pkg::TIME_STEP_RST;
         soc_start_ff <= '0;
         soc_pts_ff   <= brms_pkg::POINTS_RST;
         cur_pts_ff   <= brms_pkg::POINTS_RST;
         branches_ff  <= brms_pkg::BRANCHES_RST;
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            brms_pkg::REG_TIME_STEP:  time_step_ff <= csr_pwdata;
            brms_pkg::REG_SOC_START:  soc_start_ff <= $signed(csr_pwdata);
            brms_pkg::REG_SOC_POINTS: soc_pts_ff   <= csr_pwdata[4:0];
            brms_pkg::REG_CUR_POINTS: cur_pts_ff   <= csr_pwdata[4:0];
            brms_pkg::REG_BRANCHES:   branches_ff  <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         brms_pkg::REG_TIME_STEP:  csr_prdata = time_step_ff;
         brms_pkg::REG_SOC_START:  csr_prdata = soc_start_ff;
         brms_pkg::REG_SOC_POINTS: csr_prdata = 32'(soc_pts_ff);
         brms_pkg::REG_CUR_POINTS: csr_prdata = 32'(cur_pts_ff);
         brms_pkg::REG_BRANCHES:   csr_prdata = 32'(branches_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   logic [NW-1:0] n_soc, n_cur;
   logic [KW-1:0] nb_eff;

   always_comb begin
      n_soc = (soc_pts_ff == '0) ? NW'(1) :
              (32'(soc_pts_ff) > SOC_POINTS) ? NW'(SOC_POINTS) : NW'(soc_pts_ff);
      n_cur = (cur_pts_ff == '0) ? NW'(1) :
              (32'(cur_pts_ff) > CURRENT_POINTS) ? NW'(CURRENT_POINTS) : NW'(cur_pts_ff);
      nb_eff = (32'(branches_ff) > RC_BRANCHES) ? KW'(RC_BRANCHES) : KW'(branches_ff);
   end

   // ------------------------------------------------------------ item capture
   logic               req_accept;
   logic               cmd_ff, first_ff;
   logic signed [31:0] cur_ff, curf_ff, curs_ff, meas_ff, tval_ff;
   logic [2:0]         tsel_ff;
   logic [1:0]         bnum_ff;
   logic [3:0]         rnum_ff, cnum_ff;

   brms_pkg::seq_state_type state_ff, state_in;

   assign req_tready = (state_ff == brms_pkg::ST_IDLE);
   assign req_accept = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff   <= req_tuser[0];
         first_ff <= req_tdata[0];
         cur_ff   <= $signed(req_tdata[32:1]);
         curf_ff  <= $signed(req_tdata[64:33]);
         curs_ff  <= $signed(req_tdata[96:65]);
         meas_ff  <= $signed(req_tdata[128:97]);
         tsel_ff  <= req_tdata[131:129];
         bnum_ff  <= req_tdata[133:132];
         rnum_ff  <= req_tdata[137:134];
         cnum_ff  <= req_tdata[141:138];
         tval_ff  <= $signed(req_tdata[173:142]);
      end
   end

   // -------------------------------------------------------------- sequencer
   brms_pkg::search_phase_type phase_ff, phase_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [CW-1:0]        fcol_ff, fcol_in, scol_ff, scol_in;
   logic [SW-1:0]        row_ff, row_in;
   logic [KW-1:0]        k_ff, k_in;
   logic                 err_ff, err_in;
   logic signed [63:0]   acc_ff, acc_in, tau_ff, tau_in, den_ff, den_in;
   logic signed [31:0]   q_ff, q_in, vt_ff, vt_in, soc_ff, soc_in;
   logic signed [65:0]   prod_ff;
   logic signed [63:0]   prod64;
   logic signed [32:0]   mul_a, mul_b;
   logic signed [31:0]   vbr_ff [RC_BRANCHES];
   logic signed [31:0]   vk, step, vnew, bp;
   logic                 vbr_we, vbr_clr, tbl_we, rsp_load;
   logic                 div_start;
   logic signed [63:0]   div_num, div_den;
   logic signed [31:0]   div_quo;
   brms_pkg::div_status_type div_st;

   logic signed [31:0] sbp_rd_ff, cbp_rd_ff, cap_rd_ff, ocv_rd_ff, r0_rd_ff;
   logic signed [31:0] brr_rd_ff, brc_rd_ff;

   function automatic logic signed [KEY_W-1:0] key_of(input logic signed [31:0] x);
      logic signed [36:0] scaled;
      scaled = 37'(x) * 37'(brms_pkg::KEY_SCALE);
      return KEY_W'(scaled >>> 16);
   endfunction

   assign prod64 = prod_ff[63:0];
   assign vk     = vbr_ff[k_ff[BW-1:0]];

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      key_in   = key_ff;
      fcol_in  = fcol_ff;
      scol_in  = scol_ff;
      row_in   = row_ff;
      k_in     = k_ff;
      err_in   = err_ff;
      acc_in   = acc_ff;
      tau_in   = tau_ff;
      den_in   = den_ff;
      q_in     = q_ff;
      vt_in    = vt_ff;
      soc_in   = soc_ff;
      vbr_we   = 1'b0;
      vbr_clr  = 1'b0;
      tbl_we   = 1'b0;
      rsp_load = 1'b0;
      div_start = 1'b0;
      div_num  = prod64;
      div_den  = den_ff;
      mul_a    = 33'(cur_ff);
      mul_b    = 33'(r0_rd_ff);
      bp       = (phase_ff == brms_pkg::PH_SOC) ? sbp_rd_ff : cbp_rd_ff;
      step     = brms_pkg::sat32(prod64 >>> 16);
      vnew     = brms_pkg::sat32(64'(vk) + 64'(step));
      case (state_ff)
         brms_pkg::ST_IDLE: begin
            if (req_accept) state_in = req_tuser[0] ? brms_pkg::ST_WRITE : brms_pkg::ST_PREP;
         end
         brms_pkg::ST_WRITE: begin
            tbl_we   = 1'b1;
            state_in = brms_pkg::ST_FINISH;
         end
         brms_pkg::ST_PREP: begin
            if (first_ff) begin
               soc_in  = soc_start_ff;
               vbr_clr = 1'b1;
            end
            err_in   = 1'b0;
            acc_in   = '0;
            phase_in = brms_pkg::PH_FAST;
            key_in   = key_of(curf_ff);
            idx_in   = '0;
            state_in = brms_pkg::ST_SRCH_RD;
         end
         brms_pkg::ST_SRCH_RD: state_in = brms_pkg::ST_SRCH_CMP;
         brms_pkg::ST_SRCH_CMP: begin
            if ((NW'(idx_ff) + NW'(1) <
                 ((phase_ff == brms_pkg::PH_SOC) ? n_soc : n_cur)) &&
                (key_of(bp) < key_ff)) begin
               idx_in   = idx_ff + IW'(1);
               state_in = brms_pkg::ST_SRCH_RD;
            end else if (phase_ff == brms_pkg::PH_FAST) begin
               fcol_in  = CW'(idx_ff);
               phase_in = brms_pkg::PH_SLOW;
               key_in   = key_of(curs_ff);
               idx_in   = '0;
               state_in = brms_pkg::ST_SRCH_RD;
            end else if (phase_ff == brms_pkg::PH_SLOW) begin
               scol_in  = CW'(idx_ff);
               state_in = brms_pkg::ST_CAP_MUL;
            end else begin
               row_in   = SW'(idx_ff);
               state_in = brms_pkg::ST_BR_START;
            end
         end
         brms_pkg::ST_CAP_MUL: begin
            mul_a    = 33'(brms_pkg::SECONDS_PER_HOUR);
            mul_b    = 33'(cap_rd_ff);
            state_in = brms_pkg::ST_NUM_MUL;
         end
         brms_pkg::ST_NUM_MUL: begin
            den_in   = prod64;
            mul_a    = $signed({1'b0, time_step_ff});
            mul_b    = 33'(cur_ff);
            state_in = brms_pkg::ST_SOC_DIV_GO;
         end
         brms_pkg::ST_SOC_DIV_GO: begin
            div_start = 1'b1;
            state_in  = brms_pkg::ST_SOC_DIV_WAIT;
         end
         brms_pkg::ST_SOC_DIV_WAIT: begin
            if (div_st.done) begin
               err_in   = err_ff | div_st.zero;
               soc_in   = brms_pkg::sat32(64'(soc_ff) + 64'(div_quo));
               state_in = brms_pkg::ST_SOC_KEY;
            end
         end
         brms_pkg::ST_SOC_KEY: begin
            phase_in = brms_pkg::PH_SOC;
            key_in   = key_of(soc_ff);
            idx_in   = '0;
            state_in = brms_pkg::ST_SRCH_RD;
         end
         brms_pkg::ST_BR_START: begin
            k_in     = '0;
            state_in = (nb_eff == '0) ? brms_pkg::ST_OUT_MUL : brms_pkg::ST_BR_RD;
         end
         brms_pkg::ST_BR_RD: state_in = brms_pkg::ST_BR_TAU;
         brms_pkg::ST_BR_TAU: begin
            mul_a    = 33'(brr_rd_ff);
            mul_b    = 33'(brc_rd_ff);
            state_in = brms_pkg::ST_BR_DIV1_GO;
         end
         brms_pkg::ST_BR_DIV1_GO: begin
            tau_in    = prod64 >>> 16;
            div_start = 1'b1;
            div_num   = {{16{cur_ff[31]}}, cur_ff, 16'h0000};
            div_den   = 64'(brc_rd_ff);
            state_in  = brms_pkg::ST_BR_DIV1_WAIT;
         end
         brms_pkg::ST_BR_DIV1_WAIT: begin
            if (div_st.done) begin
               err_in   = err_ff | div_st.zero;
               q_in     = div_quo;
               state_in = brms_pkg::ST_BR_DIV2_GO;
            end
         end
         brms_pkg::ST_BR_DIV2_GO: begin
            div_start = 1'b1;
            div_num   = {{16{vk[31]}}, vk, 16'h0000};
            div_den   = tau_ff;
            state_in  = brms_pkg::ST_BR_DIV2_WAIT;
         end
         brms_pkg::ST_BR_DIV2_WAIT: begin
            if (div_st.done) begin
               err_in   = err_ff | div_st.zero;
               q_in     = brms_pkg::sat32(64'(q_ff) - 64'(div_quo));
               state_in = brms_pkg::ST_BR_MUL;
            end
         end
         brms_pkg::ST_BR_MUL: begin
            mul_a    = $signed({1'b0, time_step_ff});
            mul_b    = 33'(q_ff);
            state_in = brms_pkg::ST_BR_UPD;
         end
         brms_pkg::ST_BR_UPD: begin
            vbr_we   = 1'b1;
            acc_in   = acc_ff + 64'(vnew);
            k_in     = k_ff + KW'(1);
            state_in = (k_ff + KW'(1) < nb_eff) ? brms_pkg::ST_BR_RD : brms_pkg::ST_OUT_MUL;
         end
         brms_pkg::ST_OUT_MUL: state_in = brms_pkg::ST_OUT_SUM;
         brms_pkg::ST_OUT_SUM: begin
            vt_in    = brms_pkg::sat32(64'(ocv_rd_ff) + (prod64 >>> 16) + acc_ff);
            state_in = brms_pkg::ST_FINISH;
         end
         brms_pkg::ST_FINISH: begin
            if (!rsp_tvalid || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = brms_pkg::ST_IDLE;
            end
         end
         default: state_in = brms_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brms_pkg::ST_IDLE;
         phase_ff <= brms_pkg::PH_FAST;
         idx_ff   <= '0;
         k_ff     <= '0;
         err_ff   <= 1'b0;
         soc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         k_ff     <= k_in;
         err_ff   <= err_in;
         soc_ff   <= soc_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      fcol_ff <= fcol_in;
      scol_ff <= scol_in;
      row_ff  <= row_in;
      acc_ff  <= acc_in;
      tau_ff  <= tau_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      vt_ff   <= vt_in;
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset || vbr_clr) begin
         for (int i = 0; i < RC_BRANCHES; i++) vbr_ff[i] <= '0;
      end else if (vbr_we) begin
         vbr_ff[k_ff[BW-1:0]] <= vnew;
      end
   end

   brms_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .status (div_st),
      .quo    (div_quo)
   );

   // ---------------------------------------------------------------- tables
   logic signed [31:0] sbp_mem [SOC_POINTS];
   logic signed [31:0] cbp_mem [CURRENT_POINTS];
   logic signed [31:0] cap_mem [CURRENT_POINTS];
   logic signed [31:0] ocv_mem [CELLS];
   logic signed [31:0] r0_mem  [CELLS];
   logic signed [31:0] brr_mem [BCELLS];
   logic signed [31:0] brc_mem [BCELLS];

   logic           row_ok, crow_ok, col_ok, br_ok;
   logic [OAW-1:0] wr_cell, rd_ocv, rd_r0;
   logic [BAW-1:0] wr_bcell, rd_bcell;

   always_comb begin
      row_ok   = 32'(rnum_ff) < SOC_POINTS;
      crow_ok  = 32'(rnum_ff) < CURRENT_POINTS;
      col_ok   = 32'(cnum_ff) < CURRENT_POINTS;
      br_ok    = 32'(bnum_ff) < RC_BRANCHES;
      wr_cell  = OAW'(rnum_ff) * OAW'(CURRENT_POINTS) + OAW'(cnum_ff);
      wr_bcell = (BAW'(bnum_ff) * BAW'(SOC_POINTS) + BAW'(rnum_ff)) * BAW'(CURRENT_POINTS)
               + BAW'(cnum_ff);
      rd_ocv   = OAW'(row_ff) * OAW'(CURRENT_POINTS) + OAW'(fcol_ff);
      rd_r0    = OAW'(row_ff) * OAW'(CURRENT_POINTS) + OAW'(scol_ff);
      rd_bcell = (BAW'(k_ff[BW-1:0]) * BAW'(SOC_POINTS) + BAW'(row_ff))
               * BAW'(CURRENT_POINTS) + BAW'(scol_ff);
   end

   always_ff @(posedge clock) begin
      if (tbl_we && tsel_ff == brms_pkg::TBL_SOC_BP && row_ok)
         sbp_mem[SW'(rnum_ff)] <= tval_ff;
      sbp_rd_ff <= sbp_mem[idx_ff[SW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (tbl_we && tsel_ff == brms_pkg::TBL_CUR_BP && crow_ok)
         cbp_mem[CW'(rnum_ff)] <= tval_ff;
      cbp_rd_ff <= cbp_mem[idx_ff[CW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (tbl_we && tsel_ff == brms_pkg::TBL_CAPACITY && col_ok)
         cap_mem[CW'(cnum_ff)] <= tval_ff;
      cap_rd_ff <= cap_mem[fcol_ff];
   end

   always_ff @(posedge clock) begin
      if (tbl_we && tsel_ff == brms_pkg::TBL_OCV && row_ok && col_ok)
         ocv_mem[wr_cell] <= tval_ff;
      ocv_rd_ff <= ocv_mem[rd_ocv];
   end

   always_ff @(posedge clock) begin
      if (tbl_we && tsel_ff == brms_pkg::TBL_R0 && row_ok && col_ok)
         r0_mem[wr_cell] <= tval_ff;
      r0_rd_ff <= r0_mem[rd_r0];
   end

   always_ff @(posedge clock) begin
      if (tbl_we && tsel_ff == brms_pkg::TBL_BR_R && row_ok && col_ok && br_ok)
         brr_mem[wr_bcell] <= tval_ff;
      brr_rd_ff <= brr_mem[rd_bcell];
   end

   always_ff @(posedge clock) begin
      if (tbl_we && tsel_ff == brms_pkg::TBL_BR_C && row_ok && col_ok && br_ok)
         brc_mem[wr_bcell] <= tval_ff;
      brc_rd_ff <= brc_mem[rd_bcell];
   end

   // ---------------------------------------------------------------- output
   logic                             rsp_valid_ff;
   logic [brms_pkg::RSP_DATA_W-1:0]  rsp_data_ff;
   logic                             rsp_user_ff;
   logic signed [31:0]               resid;

   assign resid = brms_pkg::sat32(64'(meas_ff) - 64'(vt_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_user_ff <= !cmd_ff;
         if (cmd_ff) begin
            rsp_data_ff <= '0;
         end else begin
            rsp_data_ff <= {3'b000, err_ff, 4'(scol_ff), 4'(fcol_ff), 4'(row_ff),
                            resid, soc_ff, vt_ff};
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

   // ------------------------------------------------------------ assertions
   `BRMS_ASSERT_NEXT(a_busy_after_accept, req_accept, !req_tready,
      "block still ready after taking an item")
   `BRMS_ASSERT(a_div_done_waited, div_st.done,
      state_ff == brms_pkg::ST_SOC_DIV_WAIT || state_ff == brms_pkg::ST_BR_DIV1_WAIT ||
      state_ff == brms_pkg::ST_BR_DIV2_WAIT,
      "divider finished while nothing waited for it")
   `BRMS_ASSERT(a_branch_in_range, state_ff == brms_pkg::ST_BR_TAU, k_ff < nb_eff,
      "branch index beyond branches in use")
   `BRMS_ASSERT(a_result_from_finish, $rose(rsp_valid_ff),
      $past(state_ff == brms_pkg::ST_FINISH),
      "result raised outside the finish state")

endmodule

`default_nettype wire

@@ sv/brms_div.sv @@
// ----------------------------------------------------------------------------
// Battery RC model step - divider
// Signed 64/64 division, one quotient bit a cycle, truncating toward zero,
// saturated to 32 bits; a zero divisor saturates by the numerator's sign.
// ----------------------------------------------------------------------------
`default_nettype none

module brms_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [63:0]       num,
   input  logic signed [63:0]       den,
   output brms_pkg::div_status_type status,
   output logic signed [31:0]       quo
);

   brms_pkg::div_state_type state_ff, state_in;
   logic [63:0]        rem_ff, dmag_ff;
   logic [31:0]        low_ff, qacc_ff;
   logic [4:0]         cnt_ff;
   logic               neg_ff, zero_ff;
   logic signed [31:0] quo_ff;

   logic [63:0] nmag, dmag;
   logic        big;
   logic [64:0] trial, trial_sub;
   logic        qbit;
   logic [31:0] qfin;

   always_comb begin
      nmag = num[63] ? 64'(-num) : 64'(num);
      dmag = den[63] ? 64'(-den) : 64'(den);
      big  = {32'h0, nmag} >= {dmag, 32'h0};
      trial     = {rem_ff, low_ff[31]};
      trial_sub = trial - {1'b0, dmag_ff};
      qbit      = trial >= {1'b0, dmag_ff};
      qfin      = {qacc_ff[30:0], qbit};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         brms_pkg::DV_IDLE: begin
            if (start) begin
               state_in = (den == '0 || big) ? brms_pkg::DV_DONE : brms_pkg::DV_RUN;
            end
         end
         brms_pkg::DV_RUN: begin
            if (cnt_ff == 5'd31) state_in = brms_pkg::DV_DONE;
         end
         brms_pkg::DV_DONE: state_in = brms_pkg::DV_IDLE;
         default:           state_in = brms_pkg::DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brms_pkg::DV_IDLE;
         cnt_ff   <= '0;
         zero_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            brms_pkg::DV_IDLE: begin
               if (start) begin
                  cnt_ff  <= '0;
                  zero_ff <= (den == '0);
               end
            end
            brms_pkg::DV_RUN: cnt_ff <= cnt_ff + 5'd1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         brms_pkg::DV_IDLE: begin
            if (start) begin
               neg_ff  <= num[63] ^ den[63];
               dmag_ff <= dmag;
               rem_ff  <= {32'h0, nmag[63:32]};
               low_ff  <= nmag[31:0];
               qacc_ff <= '0;
               if (den == '0) begin
                  if (num > 0)       quo_ff <= brms_pkg::S32_MAX;
                  else if (num < 0)  quo_ff <= brms_pkg::S32_MIN;
                  else               quo_ff <= '0;
               end else if (big) begin
                  quo_ff <= (num[63] ^ den[63]) ? brms_pkg::S32_MIN : brms_pkg::S32_MAX;
               end
            end
         end
         brms_pkg::DV_RUN: begin
            rem_ff  <= qbit ? trial_sub[63:0] : trial[63:0];
            low_ff  <= {low_ff[30:0], 1'b0};
            qacc_ff <= qfin;
            if (cnt_ff == 5'd31) begin
               if (neg_ff) begin
                  quo_ff <= (qfin > 32'h8000_0000) ? brms_pkg::S32_MIN : $signed(-qfin);
               end else begin
                  quo_ff <= qfin[31] ? brms_pkg::S32_MAX : $signed(qfin);
               end
            end
         end
         default: ;
      endcase
   end

   assign status.done = (state_ff == brms_pkg::DV_DONE);
   assign status.zero = zero_ff;
   assign quo         = quo_ff;

endmodule

`default_nettype wire

@@ sim/battery_rc_model_step_tb.sv @@
// ----------------------------------------------------------------------------
// Battery RC model step - testbench
// Loads every table, then runs directed and random samples and table writes
// through several register settings and idling patterns. Each accepted item
// is predicted by a local fixed-point cell model; results are compared in order.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_rc_model_step_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int SPAN = 1 << 20;

   typedef struct {
      logic       cmd;
      logic [brms_pkg::REQ_DATA_W-1:0] bits;
   } req_item_type;

   typedef struct {
      logic        is_est;
      logic [31:0] vterm;
      logic [31:0] soc;
      logic [31:0] resid;
      logic [3:0]  row;
      logic [3:0]  fcol;
      logic [3:0]  scol;
      logic        derr;
   } cell_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [brms_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [brms_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   battery_rc_model_step dut (.*);

   req_item_type    sample_q[$];
   cell_result_type result_q[$];
   logic req_took = 1'b0;
   int send_idle = 0, recv_idle = 0;
   int mismatches = 0;
   int cycles = 0;

   // cell model copy of registers and state
   logic [31:0] step_dt = brms_pkg::TIME_STEP_RST;
   longint soc_init = 0;
   logic [4:0] soc_pts = brms_pkg::POINTS_RST, cur_pts = brms_pkg::POINTS_RST;
   logic [2:0] n_branches = brms_pkg::BRANCHES_RST;
   longint soc_acc = 0;
   longint v_branch[4] = '{default: 0};
   longint soc_bp[16], cur_bp[16], cap_tab[16];
   longint ocv_tab[256], r0_tab[256], rb_tab[1024], cb_tab[1024];

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint safe_div(input longint num, input longint den, inout bit err);
      if (den == 0) begin
         err = 1'b1;
         return num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
      end
      return clip32(num / den);
   endfunction

   function automatic int search_bp(input bit soc_axis, input int n, input longint v);
      longint key;
      int i;
      key = (v * brms_pkg::KEY_SCALE) >>> 16;
      i = 0;
      while (i + 1 < n &&
             (((soc_axis ? soc_bp[i] : cur_bp[i]) * brms_pkg::KEY_SCALE) >>> 16) < key)
         i++;
      return i;
   endfunction

   function automatic cell_result_type advance_cell(input logic cmd,
                                                    input logic [brms_pkg::REQ_DATA_W-1:0] d);
      cell_result_type res;
      longint cur, fast, slow, meas, dt, vt, r, c, tau, vk, q1, q2, diff;
      int sel, br, row, col, n_soc, n_cur, nb, fcol, scol, bc, pts_s, pts_c, nbr;
      longint val;
      bit err;
      res = '{default: '0};
      err = 1'b0;
      if (cmd) begin
         sel = int'(d[131:129]); br = int'(d[133:132]);
         row = int'(d[137:134]); col = int'(d[141:138]);
         val = longint'($signed(d[173:142]));
         bc = (br * 16 + row) * 16 + col;
         case (sel)
            brms_pkg::TBL_SOC_BP:   soc_bp[row] = val;
            brms_pkg::TBL_CUR_BP:   cur_bp[row] = val;
            brms_pkg::TBL_CAPACITY: cap_tab[col] = val;
            brms_pkg::TBL_OCV:      ocv_tab[row * 16 + col] = val;
            brms_pkg::TBL_R0:       r0_tab[row * 16 + col] = val;
            brms_pkg::TBL_BR_R:     rb_tab[bc] = val;
            brms_pkg::TBL_BR_C:     cb_tab[bc] = val;
            default: ;
         endcase
         return res;
      end
      if (d[0]) begin
         soc_acc = soc_init;
         v_branch = '{default: 0};
      end
      cur  = longint'($signed(d[32:1]));
      fast = longint'($signed(d[64:33]));
      slow = longint'($signed(d[96:65]));
      meas = longint'($signed(d[128:97]));
      dt = longint'({32'b0, step_dt});
      pts_s = int'(soc_pts);
      pts_c = int'(cur_pts);
      nbr = int'(n_branches);
      n_soc = pts_s < 1 ? 1 : (pts_s > 16 ? 16 : pts_s);
      n_cur = pts_c < 1 ? 1 : (pts_c > 16 ? 16 : pts_c);
      nb = nbr > 4 ? 4 : nbr;
      fcol = search_bp(1'b0, n_cur, fast);
      scol = search_bp(1'b0, n_cur, slow);
      soc_acc = clip32(soc_acc + safe_div(dt * cur,
                                          brms_pkg::SECONDS_PER_HOUR * cap_tab[fcol], err));
      row = search_bp(1'b1, n_soc, soc_acc);
      for (int k = 0; k < nb; k++) begin
         bc = (k * 16 + row) * 16 + scol;
         r = rb_tab[bc];
         c = cb_tab[bc];
         tau = (r * c) >>> 16;
         vk = v_branch[k];
         q1 = safe_div(cur * 65536, c, err);
         q2 = safe_div(vk * 65536, tau, err);
         diff = clip32(q1 - q2);
         v_branch[k] = clip32(vk + clip32((dt * diff) >>> 16));
      end
      vt = ocv_tab[row * 16 + fcol] + ((cur * r0_tab[row * 16 + scol]) >>> 16);
      for (int k = 0; k < nb; k++) vt += v_branch[k];
      vt = clip32(vt);
      res.is_est = 1'b1;
      res.vterm = vt[31:0];
      res.soc = soc_acc[31:0];
      res.resid = 32'(clip32(meas - vt));
      res.row = row[3:0];
      res.fcol = fcol[3:0];
      res.scol = scol[3:0];
      res.derr = err;
      return res;
   endfunction

   // sender: hold the item until it is taken
   always @(negedge clock) begin
      req_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (sample_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
            it = sample_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= it.bits;
            req_tuser <= it.cmd;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= $urandom_range(0, 99) >= recv_idle;
   end

   always @(posedge clock) begin
      cell_result_type exp_r;
      logic [brms_pkg::RSP_DATA_W-1:0] d;
      req_took <= req_tvalid && req_tready && !reset;
      if (!reset && req_tvalid && req_tready)
         result_q.push_back(advance_cell(req_tuser[0], req_tdata));
      if (!reset && rsp_tvalid && rsp_tready) begin
         d = rsp_tdata;
         if (result_q.size() == 0) begin
            $error("result item with nothing expected");
            mismatches++;
         end else begin
            exp_r = result_q.pop_front();
            if (rsp_tuser[0] !== exp_r.is_est) begin
               $error("is_estimate exp %0h got %0h", exp_r.is_est, rsp_tuser[0]); mismatches++;
            end
            if (d[31:0] !== exp_r.vterm) begin
               $error("terminal_voltage exp %0h got %0h", exp_r.vterm, d[31:0]); mismatches++;
            end
            if (d[63:32] !== exp_r.soc) begin
               $error("state_of_charge exp %0h got %0h", exp_r.soc, d[63:32]); mismatches++;
            end
            if (d[95:64] !== exp_r.resid) begin
               $error("residual exp %0h got %0h", exp_r.resid, d[95:64]); mismatches++;
            end
            if (d[99:96] !== exp_r.row) begin
               $error("soc_row exp %0d got %0d", exp_r.row, d[99:96]); mismatches++;
            end
            if (d[103:100] !== exp_r.fcol) begin
               $error("fast_column exp %0d got %0d", exp_r.fcol, d[103:100]); mismatches++;
            end
            if (d[107:104] !== exp_r.scol) begin
               $error("slow_column exp %0d got %0d", exp_r.scol, d[107:104]); mismatches++;
            end
            if (d[108] !== exp_r.derr) begin
               $error("divide_error exp %0d got %0d", exp_r.derr, d[108]); mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [31:0] rand_q(input int span);
      case ($urandom_range(0, 15))
         0: return 32'h0;
         1: return $urandom;
         2: return brms_pkg::S32_MAX;
         3: return brms_pkg::S32_MIN;
         default: return $urandom_range(0, 2 * span) - span;
      endcase
   endfunction

   function automatic req_item_type step_item(input bit fr, input logic [31:0] cur, fast, slow,
                                              meas);
      req_item_type it;
      it.cmd = 1'b0;
      it.bits = {2'b0, 32'($urandom), 13'($urandom_range(0, 8191)), meas, slow, fast, cur, fr};
      return it;
   endfunction

   function automatic req_item_type write_item(input logic [2:0] sel, input int br, row, col,
                                               input logic [31:0] val);
      req_item_type it;
      logic [1:0] b;
      logic [3:0] r, c;
      b = 2'(br); r = 4'(row); c = 4'(col);
      it.cmd = 1'b1;
      it.bits = {2'b0, val, c, r, b, sel, $urandom, $urandom, $urandom, $urandom,
                 1'($urandom)};
      return it;
   endfunction

   task automatic drain(input int pause);
      while (sample_q.size() > 0 || req_tvalid || result_q.size() > 0) @(posedge clock);
      repeat (pause) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         brms_pkg::REG_TIME_STEP:  step_dt = val;
         brms_pkg::REG_SOC_START:  soc_init = longint'($signed(val));
         brms_pkg::REG_SOC_POINTS: soc_pts = val[4:0];
         brms_pkg::REG_CUR_POINTS: cur_pts = val[4:0];
         brms_pkg::REG_BRANCHES:   n_branches = val[2:0];
         default: ;
      endcase
   endtask

   task automatic random_items(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 9) == 0)
               sample_q.push_back(write_item(3'd7, $urandom, $urandom, $urandom, $urandom));
            else
               sample_q.push_back(write_item(3'($urandom_range(0, 6)), $urandom, $urandom,
                                             $urandom, rand_q(SPAN)));
         end else begin
            sample_q.push_back(step_item($urandom_range(0, 9) == 0, rand_q(SPAN),
                               rand_q(SPAN), rand_q(SPAN), rand_q(SPAN)));
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle = 32; recv_idle = 76;
      // load every entry so no step reads an unwritten one
      for (int i = 0; i < 16; i++) begin
         sample_q.push_back(write_item(brms_pkg::TBL_SOC_BP, 0, i, 0, rand_q(SPAN)));
         sample_q.push_back(write_item(brms_pkg::TBL_CUR_BP, 0, i, 0, rand_q(SPAN)));
         sample_q.push_back(write_item(brms_pkg::TBL_CAPACITY, 0, 0, i, rand_q(SPAN)));
      end
      for (int r = 0; r < 16; r++)
         for (int c = 0; c < 16; c++) begin
            sample_q.push_back(write_item(brms_pkg::TBL_OCV, 0, r, c, rand_q(SPAN)));
            sample_q.push_back(write_item(brms_pkg::TBL_R0, 0, r, c, rand_q(SPAN)));
            for (int b = 0; b < 4; b++) begin
               sample_q.push_back(write_item(brms_pkg::TBL_BR_R, b, r, c, rand_q(SPAN)));
               sample_q.push_back(write_item(brms_pkg::TBL_BR_C, b, r, c, rand_q(SPAN)));
            end
         end
      // extremes, run start, zero divisors and an unknown table
      sample_q.push_back(step_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h0));
      sample_q.push_back(step_item(1'b0, brms_pkg::S32_MAX, brms_pkg::S32_MAX,
                                   brms_pkg::S32_MAX, brms_pkg::S32_MIN));
      sample_q.push_back(step_item(1'b0, brms_pkg::S32_MIN, brms_pkg::S32_MIN,
                                   brms_pkg::S32_MIN, brms_pkg::S32_MAX));
      sample_q.push_back(write_item(brms_pkg::TBL_CAPACITY, 0, 0, 0, 32'h0));
      sample_q.push_back(write_item(brms_pkg::TBL_BR_C, 0, 0, 0, 32'h0));
      sample_q.push_back(step_item(1'b1, 32'h0001_0000, brms_pkg::S32_MIN, brms_pkg::S32_MIN,
                                   32'h0));
      sample_q.push_back(step_item(1'b0, 32'hffff_0000, brms_pkg::S32_MIN, brms_pkg::S32_MIN,
                                   brms_pkg::S32_MAX));
      sample_q.push_back(write_item(3'd7, 3, 15, 15, 32'hffff_ffff));
      sample_q.push_back(write_item(brms_pkg::TBL_OCV, 3, 15, 15, brms_pkg::S32_MAX));
      sample_q.push_back(write_item(brms_pkg::TBL_R0, 0, 15, 15, brms_pkg::S32_MIN));
      sample_q.push_back(step_item(1'b1, $urandom, 32'h0, 32'h0, $urandom));
      for (int stage = 0; stage < 6; stage++) begin
         send_idle = stage < 2 ? 32 : (stage < 4 ? 76 : 0);
         recv_idle = stage < 2 ? 76 : (stage < 4 ? 32 : 0);
         case (stage)
            1: begin
               csr_write(brms_pkg::REG_TIME_STEP, 32'd1);
               csr_write(brms_pkg::REG_SOC_START, brms_pkg::S32_MAX);
               csr_write(brms_pkg::REG_SOC_POINTS, 32'd0);
               csr_write(brms_pkg::REG_CUR_POINTS, 32'd31);
               csr_write(brms_pkg::REG_BRANCHES, 32'd7);
            end
            2: begin
               csr_write(brms_pkg::REG_TIME_STEP, 32'hffff_ffff);
               csr_write(brms_pkg::REG_SOC_START, brms_pkg::S32_MIN);
               csr_write(brms_pkg::REG_SOC_POINTS, 32'd1);
               csr_write(brms_pkg::REG_CUR_POINTS, 32'd1);
               csr_write(brms_pkg::REG_BRANCHES, 32'd0);
            end
            3: begin
               csr_write(brms_pkg::REG_TIME_STEP, $urandom_range(1, 32'h40000));
               csr_write(brms_pkg::REG_SOC_START, rand_q(SPAN));
               csr_write(brms_pkg::REG_SOC_POINTS, $urandom_range(1, 16));
               csr_write(brms_pkg::REG_CUR_POINTS, $urandom_range(1, 16));
               csr_write(brms_pkg::REG_BRANCHES, 32'd4);
            end
            4: begin
               csr_write(brms_pkg::REG_TIME_STEP, $urandom);
               csr_write(brms_pkg::REG_SOC_START, $urandom);
               csr_write(brms_pkg::REG_SOC_POINTS, $urandom);
               csr_write(brms_pkg::REG_CUR_POINTS, $urandom);
               csr_write(brms_pkg::REG_BRANCHES, $urandom);
            end
            5: begin
               csr_write(brms_pkg::REG_TIME_STEP, brms_pkg::TIME_STEP_RST);
               csr_write(brms_pkg::REG_SOC_START, 32'd0);
               csr_write(brms_pkg::REG_SOC_POINTS, 32'd16);
               csr_write(brms_pkg::REG_CUR_POINTS, 32'd16);
               csr_write(brms_pkg::REG_BRANCHES, 32'd4);
            end
            default: ;
         endcase
         sample_q.push_back(step_item(1'b1, rand_q(SPAN), rand_q(SPAN), rand_q(SPAN),
                                      rand_q(SPAN)));
         random_items(150);
         drain(20);
      end
      drain(600);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
